@@ src/dfsw_pkg.sv @@
// Shared types and constants for the depth-first timestamp walker.
// Used by dfsw_graph and dfs_timestamp_walker_unit; depends on nothing.
package dfsw_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = VIDX_W + 1;
  localparam int TIME_W = 6;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD = 2'd1;
  localparam logic [1:0] FUNC_RUN = 2'd2;

  localparam logic [1:0] ADDR_NUM_VERTICES = 2'd0;
  localparam logic [4:0] NUM_VERTICES_RESET = 5'd16;

  typedef enum logic [1:0] {
    COLOR_WHITE,
    COLOR_GRAY,
    COLOR_BLACK
  } color_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic add;
    logic [VIDX_W-1:0] src;
    logic [VIDX_W-1:0] dst;
  } graph_cmd_t;

endpackage

@@ src/dfs_timestamp_walker_unit.sv @@
// Depth-first forest walker with discovery/finish timestamps over a 16-vertex graph.
// Clear and add-edge items leave busy low, and the block is ready again in the next cycle.
// A run item keeps busy high through the walk (n = vertices in use): one
// neighbor test per cycle in the scan loop, a root step per root candidate, then the
// n result beats, one per cycle, vertex 0 first, with last on the final one. The
// receiver cannot stall, so each beat is valid only in the cycle strobe is high.
// Depends on dfsw_pkg and dfsw_graph.
module dfs_timestamp_walker_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        func,
  input  logic [3:0]                        edge_source,
  input  logic [3:0]                        edge_target,
  output logic                              strobe,
  output logic [3:0]                        vertex,
  output logic                              has_parent,
  output logic [3:0]                        parent,
  output logic [5:0]                        discovery_time,
  output logic [5:0]                        finish_time,
  output logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [1:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int NV = dfsw_pkg::MAX_VERTICES;
  localparam int VW = dfsw_pkg::VIDX_W;
  localparam int CW = dfsw_pkg::CNT_W;
  localparam int TW = dfsw_pkg::TIME_W;

  dfsw_pkg::state_t state, state_next;

  logic [4:0]           num_vertices;
  logic [CW-1:0]        n_act;
  logic                 accept;
  dfsw_pkg::graph_cmd_t gcmd;
  logic [NV-1:0]        row;

  dfsw_pkg::color_t     color [NV];
  logic [VW:0]          parent_of [NV];
  logic [TW-1:0]        disc [NV];
  logic [TW-1:0]        fin [NV];
  logic [VW-1:0]        stack_v [NV];
  logic [CW-1:0]        stack_w [NV];

  logic [CW-1:0]        root;
  logic [VW-1:0]        cur_v;
  logic [CW-1:0]        cur_w;
  logic [VW-1:0]        sp;
  logic [TW-1:0]        tick;
  logic [VW-1:0]        emit_idx;

  logic                 root_in;
  logic                 root_white;
  logic                 scan_in;
  logic                 scan_hit;
  logic                 emit_last;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= dfsw_pkg::NUM_VERTICES_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == dfsw_pkg::ADDR_NUM_VERTICES) begin
      num_vertices <= pwdata[4:0];
    end
  end

  assign prdata = (paddr == dfsw_pkg::ADDR_NUM_VERTICES) ? {27'd0, num_vertices} : 32'd0;

  always_comb begin
    if (num_vertices == 5'd0) begin
      n_act = CW'(1);
    end else if (num_vertices > 5'(NV)) begin
      n_act = CW'(NV);
    end else begin
      n_act = CW'(num_vertices);
    end
  end

  // graph storage
  assign busy   = (state != dfsw_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign gcmd.clear = accept && func == dfsw_pkg::FUNC_CLEAR;
  assign gcmd.add   = accept && func == dfsw_pkg::FUNC_ADD;
  assign gcmd.src   = edge_source;
  assign gcmd.dst   = edge_target;

  dfsw_graph u_graph (
    .clk     (clk),
    .rst     (rst),
    .cmd     (gcmd),
    .row_sel (cur_v),
    .row     (row)
  );

  // shared scan test
  assign root_in    = root < n_act;
  assign root_white = color[root[VW-1:0]] == dfsw_pkg::COLOR_WHITE;
  assign scan_in    = cur_w < n_act;
  assign scan_hit   = scan_in && row[cur_w[VW-1:0]] &&
                      color[cur_w[VW-1:0]] == dfsw_pkg::COLOR_WHITE;
  assign emit_last  = {1'b0, emit_idx} == n_act - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfsw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dfsw_pkg::ST_IDLE: begin
        if (accept && func == dfsw_pkg::FUNC_RUN) begin
          state_next = dfsw_pkg::ST_ROOT;
        end
      end
      dfsw_pkg::ST_ROOT: begin
        if (!root_in) begin
          state_next = dfsw_pkg::ST_EMIT;
        end else if (root_white) begin
          state_next = dfsw_pkg::ST_SCAN;
        end
      end
      dfsw_pkg::ST_SCAN: begin
        if (!scan_in && sp == '0) begin
          state_next = dfsw_pkg::ST_ROOT;
        end
      end
      dfsw_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_next = dfsw_pkg::ST_IDLE;
        end
      end
      default: state_next = dfsw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      dfsw_pkg::ST_IDLE: begin
        if (accept && func == dfsw_pkg::FUNC_RUN) begin
          for (int i = 0; i < NV; i++) begin
            color[i]     <= dfsw_pkg::COLOR_WHITE;
            parent_of[i] <= '0;
            disc[i]      <= '0;
            fin[i]       <= '0;
          end
          tick     <= '0;
          root     <= '0;
          sp       <= '0;
          emit_idx <= '0;
        end
      end
      dfsw_pkg::ST_ROOT: begin
        if (root_in) begin
          root <= root + CW'(1);
          if (root_white) begin
            tick                   <= tick + TW'(1);
            disc[root[VW-1:0]]     <= tick + TW'(1);
            color[root[VW-1:0]]    <= dfsw_pkg::COLOR_GRAY;
            cur_v                  <= root[VW-1:0];
            cur_w                  <= '0;
            sp                     <= '0;
          end
        end
      end
      dfsw_pkg::ST_SCAN: begin
        if (scan_in) begin
          if (scan_hit) begin
            stack_v[sp]               <= cur_v;
            stack_w[sp]               <= cur_w + CW'(1);
            sp                        <= sp + VW'(1);
            parent_of[cur_w[VW-1:0]]  <= {1'b1, cur_v};
            tick                      <= tick + TW'(1);
            disc[cur_w[VW-1:0]]       <= tick + TW'(1);
            color[cur_w[VW-1:0]]      <= dfsw_pkg::COLOR_GRAY;
            cur_v                     <= cur_w[VW-1:0];
            cur_w                     <= '0;
          end else begin
            cur_w <= cur_w + CW'(1);
          end
        end else begin
          color[cur_v] <= dfsw_pkg::COLOR_BLACK;
          tick         <= tick + TW'(1);
          fin[cur_v]   <= tick + TW'(1);
          if (sp != '0) begin
            cur_v <= stack_v[sp - VW'(1)];
            cur_w <= stack_w[sp - VW'(1)];
            sp    <= sp - VW'(1);
          end
        end
      end
      dfsw_pkg::ST_EMIT: begin
        emit_idx <= emit_idx + VW'(1);
      end
      default: begin
      end
    endcase
  end

  // result beats
  assign strobe         = (state == dfsw_pkg::ST_EMIT);
  assign vertex         = emit_idx;
  assign has_parent     = parent_of[emit_idx][VW];
  assign parent         = parent_of[emit_idx][VW-1:0];
  assign discovery_time = disc[emit_idx];
  assign finish_time    = fin[emit_idx];
  assign last           = strobe && emit_last;

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat outside a run");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !busy)
    else $error("block still busy after last beat");

  a_beats_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap in result beats");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && func == dfsw_pkg::FUNC_RUN) |=> (busy && !strobe))
    else $error("run item did not start the walk");

  a_edit_quick: assert property (@(posedge clk) disable iff (rst)
    (accept && func != dfsw_pkg::FUNC_RUN) |=> !busy)
    else $error("edit item left block busy");

endmodule

@@ src/dfsw_graph.sv @@
// Adjacency bit matrix: row s, bit t marks edge s->t; one row read per cycle.
// Depends on dfsw_pkg.
module dfsw_graph (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dfsw_pkg::graph_cmd_t                 cmd,
  input  logic [dfsw_pkg::VIDX_W-1:0]          row_sel,
  output logic [dfsw_pkg::MAX_VERTICES-1:0]    row
);

  logic [dfsw_pkg::MAX_VERTICES-1:0] adjacency [dfsw_pkg::MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < dfsw_pkg::MAX_VERTICES; i++) begin
        adjacency[i] <= '0;
      end
    end else if (cmd.add) begin
      adjacency[cmd.src][cmd.dst] <= 1'b1;
    end
  end

  assign row = adjacency[row_sel];

endmodule
